### hdl/hsf_pkg.sv
// ----------------------------------------------------------------------------
// hsf_pkg
// Shared types, register indexes and helpers of the spiral hole fill block.
// ----------------------------------------------------------------------------
package hsf_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_RADIUS = 2'd2;

  localparam logic [8:0] IMAGE_WIDTH_RST   = 9'd256;
  localparam logic [8:0] IMAGE_HEIGHT_RST  = 9'd256;
  localparam logic [4:0] SEARCH_RADIUS_RST = 5'd5;

  // default geometry
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MAX_RADIUS_DEF = 16;

  // the radius register is 5 bits, so the walk never exceeds 31
  localparam int RADIUS_W = 5;
  localparam int OFS_W    = 7;   // signed spiral offset, covers +/-63
  localparam int CNT_W    = 12;  // spiral position count, up to 63*63

  // coordinates follow the 9-bit size registers
  typedef logic [8:0] coord_t;

  // one stored pixel
  typedef struct packed {
    logic               mask;
    logic               bg_nan;
    logic signed [15:0] bg;
    logic               disp_nan;
    logic signed [15:0] disp;
  } pixel_t;

  // control into the spiral walker
  typedef struct packed {
    logic start;
    logic stop;
  } spiral_cmd_t;

  // one neighbor position out of the spiral walker
  typedef struct packed {
    logic   vld;
    logic   first;
    logic   last;
    coord_t xx;
    coord_t yy;
  } spiral_tap_t;

  // strictly positive and not NaN
  function automatic logic is_positive(input logic nan, input logic signed [15:0] val);
    is_positive = !nan && (val > 16'sd0);
  endfunction

endpackage

### hdl/hsf_if.sv
// ----------------------------------------------------------------------------
// hsf_if
// Request and result channels of the spiral hole fill block.
// ----------------------------------------------------------------------------
interface hsf_req_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [7:0]         column;
  logic [7:0]         row;
  logic signed [15:0] disparity;
  logic               disparity_nan;
  logic signed [15:0] background;
  logic               background_nan;
  logic               in_mask;

  modport source (
    output valid, command, column, row, disparity, disparity_nan,
           background, background_nan, in_mask,
    input  ready
  );
  modport sink (
    input  valid, command, column, row, disparity, disparity_nan,
           background, background_nan, in_mask,
    output ready
  );
endinterface

interface hsf_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] filled_disparity;
  logic               filled_nan;

  modport source (output valid, filled_disparity, filled_nan, input ready);
  modport sink   (input valid, filled_disparity, filled_nan, output ready);
endinterface

### hdl/hsf_frame_mem.sv
// ----------------------------------------------------------------------------
// hsf_frame_mem
// Frame memory of pixels: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hsf_frame_mem import hsf_pkg::*; #(
  parameter int DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pixel_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output pixel_t        rd_data
);

  pixel_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered: data arrives in the cycle after the address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/hsf_spiral.sv
// ----------------------------------------------------------------------------
// hsf_spiral
// Clockwise outward square spiral walker, one clamped neighbor per cycle.
// ----------------------------------------------------------------------------
module hsf_spiral import hsf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  spiral_cmd_t         cmd,
  input  coord_t              col,
  input  coord_t              row,
  input  coord_t              w_last,
  input  coord_t              h_last,
  input  logic [RADIUS_W-1:0] radius,
  output spiral_tap_t         tap
);

  logic                    active;
  logic signed [OFS_W-1:0] x;
  logic signed [OFS_W-1:0] y;
  logic signed [1:0]       dx;
  logic signed [1:0]       dy;
  logic [CNT_W-1:0]        idx;
  logic [CNT_W-1:0]        idx_last;
  coord_t                  ccol;
  coord_t                  crow;
  coord_t                  cw_last;
  coord_t                  ch_last;

  logic                    tap_vld;
  logic                    tap_first;
  logic                    tap_last;
  coord_t                  tap_xx;
  coord_t                  tap_yy;

  logic [CNT_W-1:0]        side;
  logic                    turn;
  logic signed [1:0]       dx_next;
  logic signed [1:0]       dy_next;
  logic signed [10:0]      sx;
  logic signed [10:0]      sy;
  coord_t                  xx_next;
  coord_t                  yy_next;

  // side of the square, wide enough for its square
  assign side = CNT_W'({radius, 1'b1});

  assign tap = '{vld: tap_vld, first: tap_first, last: tap_last, xx: tap_xx, yy: tap_yy};

  // turn rule and new heading
  always_comb begin
    turn = (x == y) || ((x < 0) && (x == -y)) || ((x > 0) && (x == (7'sd1 - y)));
    dx_next = turn ? -dy : dx;
    dy_next = turn ? dx : dy;
  end

  // neighbor coordinates clamped to the image
  always_comb begin
    sx = $signed({2'b00, ccol}) + 11'(x);
    sy = $signed({2'b00, crow}) + 11'(y);
    if (sx < 0) begin
      xx_next = '0;
    end else if (sx > $signed({2'b00, cw_last})) begin
      xx_next = cw_last;
    end else begin
      xx_next = sx[8:0];
    end
    if (sy < 0) begin
      yy_next = '0;
    end else if (sy > $signed({2'b00, ch_last})) begin
      yy_next = ch_last;
    end else begin
      yy_next = sy[8:0];
    end
  end

  // walker control
  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      tap_vld <= 1'b0;
    end else if (cmd.stop) begin
      active  <= 1'b0;
      tap_vld <= 1'b0;
    end else if (cmd.start) begin
      active  <= 1'b1;
      tap_vld <= 1'b0;
    end else begin
      tap_vld <= active;
      if (active && (idx == idx_last)) begin
        active <= 1'b0;
      end
    end
  end

  // walker position and output tap
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x        <= '0;
      y        <= '0;
      dx       <= 2'sd0;
      dy       <= -2'sd1;
      idx      <= '0;
      idx_last <= side * side - 1'b1;
      ccol     <= col;
      crow     <= row;
      cw_last  <= w_last;
      ch_last  <= h_last;
    end else if (active) begin
      dx  <= dx_next;
      dy  <= dy_next;
      x   <= x + OFS_W'(dx_next);
      y   <= y + OFS_W'(dy_next);
      idx <= idx + 1'b1;
    end
    tap_first <= (idx == '0);
    tap_last  <= (idx == idx_last);
    tap_xx    <= xx_next;
    tap_yy    <= yy_next;
  end

endmodule

### hdl/spiral_search_hole_fill.sv
// ----------------------------------------------------------------------------
// spiral_search_hole_fill
// Disparity hole filling by spiral search over a frame memory.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req      in   valid/ready        command, column, row, disparity(_nan),
//                                   background(_nan), in_mask
//  res      out  valid/ready        filled_disparity, filled_nan
//  cfg      in   cfg_write          cfg_index, cfg_data
//
//  A load writes the frame memory at acceptance if its column and row lie
//  inside the image. A query holds req.ready low from acceptance until its
//  result enters the output register; the walk reads at most (2r+1)^2
//  spiral positions (the hit included), one position a cycle through the
//  single frame memory read port.
//  A result waits in the output register; a query that finishes while it is
//  still not taken holds until it is.
//  Reset (synchronous) clears control and restores the registers; memory
//  contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module spiral_search_hole_fill import hsf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  hsf_req_if.sink               req,
  hsf_res_if.source             res,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WCAP  = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
  localparam int HCAP  = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
  localparam int RCAP  = (MAX_RADIUS > 31) ? 31 : MAX_RADIUS;

  typedef enum logic [2:0] {
    IDLE   = 3'b001,
    WALK   = 3'b010,
    FINISH = 3'b100
  } state_t;

  state_t              state;
  logic [8:0]          image_width;
  logic [8:0]          image_height;
  logic [4:0]          search_radius;

  coord_t              w_eff;
  coord_t              h_eff;
  logic [4:0]          r_eff;
  coord_t              qcol;
  coord_t              qrow;

  spiral_cmd_t         sp_cmd;
  spiral_tap_t         tap;
  pixel_t              wr_data;
  pixel_t              rd_data;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic                accept;
  logic                res_load;

  logic                vld2;
  logic                first2;
  logic                last2;
  logic signed [15:0]  cen_disp;
  logic                cen_nan;
  logic signed [15:0]  cen_bg;
  logic                cen_bg_nan;

  logic                done;
  logic signed [15:0]  pick_val;
  logic                pick_nan;
  logic signed [15:0]  sel_disp;
  logic                sel_nan;
  logic signed [15:0]  sel_bg;
  logic                sel_bg_nan;
  logic signed [15:0]  fin_val;
  logic                fin_nan;
  logic signed [15:0]  fin_val_next;
  logic                fin_nan_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= IMAGE_WIDTH_RST;
      image_height  <= IMAGE_HEIGHT_RST;
      search_radius <= SEARCH_RADIUS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        REG_SEARCH_RADIUS: search_radius <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // effective image size and radius
  always_comb begin
    if (image_width == '0) begin
      w_eff = 9'd1;
    end else if (int'(image_width) > WCAP) begin
      w_eff = 9'(WCAP);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = 9'd1;
    end else if (int'(image_height) > HCAP) begin
      h_eff = 9'(HCAP);
    end else begin
      h_eff = image_height;
    end
    r_eff = (int'(search_radius) > RCAP) ? 5'(RCAP) : search_radius;
  end

  // query position saturated to the image
  always_comb begin
    qcol = ({1'b0, req.column} > w_eff - 1'b1) ? w_eff - 1'b1 : {1'b0, req.column};
    qrow = ({1'b0, req.row} > h_eff - 1'b1) ? h_eff - 1'b1 : {1'b0, req.row};
  end

  assign req.ready = (state == IDLE);
  assign accept    = req.valid && req.ready;

  // load path into the frame memory
  always_comb begin
    wr_en = accept && !req.command && ({1'b0, req.column} < w_eff) &&
            ({1'b0, req.row} < h_eff);
    wr_addr = AW'(int'(req.row) * MAX_WIDTH + int'(req.column));
    wr_data.mask     = req.in_mask;
    wr_data.bg_nan   = req.background_nan;
    wr_data.bg       = req.background;
    wr_data.disp_nan = req.disparity_nan;
    wr_data.disp     = req.disparity;
  end

  assign rd_addr = AW'(int'(tap.yy) * MAX_WIDTH + int'(tap.xx));

  // spiral start on a query, stop on a decision
  assign sp_cmd.start = accept && req.command;
  assign sp_cmd.stop  = (state == WALK) && done;

  hsf_spiral u_spiral (
    .clk    (clk),
    .rst    (rst),
    .cmd    (sp_cmd),
    .col    (qcol),
    .row    (qrow),
    .w_last (w_eff - 1'b1),
    .h_last (h_eff - 1'b1),
    .radius (r_eff),
    .tap    (tap)
  );

  hsf_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (tap.vld),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // read data tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= tap.vld && (state == WALK) && !done;
    end
    first2 <= tap.first;
    last2  <= tap.last;
  end

  // center pixel, captured with the first spiral read
  always_comb begin
    sel_disp   = first2 ? rd_data.disp     : cen_disp;
    sel_nan    = first2 ? rd_data.disp_nan : cen_nan;
    sel_bg     = first2 ? rd_data.bg       : cen_bg;
    sel_bg_nan = first2 ? rd_data.bg_nan   : cen_bg_nan;
  end

  always_ff @(posedge clk) begin
    if (vld2 && first2) begin
      cen_disp   <= rd_data.disp;
      cen_nan    <= rd_data.disp_nan;
      cen_bg     <= rd_data.bg;
      cen_bg_nan <= rd_data.bg_nan;
    end
  end

  // decision on each returned neighbor
  always_comb begin
    done     = 1'b0;
    pick_val = sel_disp;
    pick_nan = sel_nan;
    if (vld2) begin
      priority if (first2 && (!rd_data.mask ||
                              is_positive(rd_data.disp_nan, rd_data.disp))) begin
        done = 1'b1;
      end else if (!first2 && is_positive(rd_data.disp_nan, rd_data.disp)) begin
        done     = 1'b1;
        pick_val = rd_data.disp;
        pick_nan = 1'b0;
      end else if (last2) begin
        done = 1'b1;
      end
    end
    // zero or NaN falls back to the background
    if (pick_nan || (pick_val == 16'sd0)) begin
      fin_nan_next = sel_bg_nan;
      fin_val_next = sel_bg_nan ? 16'sd0 : sel_bg;
    end else begin
      fin_nan_next = 1'b0;
      fin_val_next = pick_val;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == WALK) && done) begin
      fin_val <= fin_val_next;
      fin_nan <= fin_nan_next;
    end
  end

  // output register takes the answer once it is free
  assign res_load = (state == FINISH) && (!res.valid || res.ready);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      res.valid <= 1'b0;
    end else begin
      if (res_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept && req.command) begin
            state <= WALK;
          end
        end
        WALK: begin
          if (done) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (res_load) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.filled_disparity <= fin_val;
      res.filled_nan       <= fin_nan;
    end
  end

endmodule
